/* rtl/core/lpg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants for the line pixel generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int COORD_W      = 6;
    localparam int TILE_SIZE_DEF = 64;
    localparam int ERR_W        = COORD_W + 3;
    localparam int S_DATA_W     = 4 * COORD_W;
    localparam int M_DATA_W     = ((2 * COORD_W + 7) / 8) * 8;

    typedef logic [COORD_W-1:0] coord_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SWAP,
        ST_ORDER,
        ST_DRAW
    } lpg_state_t;

    typedef struct packed
    {
        logic load;
        logic swap;
        logic order;
        logic emit;
    } lpg_cmd_t;

    typedef struct packed
    {
        logic line_end;
        logic out_free;
    } lpg_status_t;

endpackage

/* rtl/core/lpg_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_ctrl
// Sequencer: capture endpoints, swap axes, order endpoints, step the line.
// ----------------------------------------------------------------------------
module lpg_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lpg_pkg::lpg_status_t status,
    output lpg_pkg::lpg_cmd_t    cmd
);

    lpg_pkg::lpg_state_t state_reg;
    lpg_pkg::lpg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpg_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = lpg_pkg::ST_SWAP;
                end
            end
            lpg_pkg::ST_SWAP:
            begin
                state_next = lpg_pkg::ST_ORDER;
            end
            lpg_pkg::ST_ORDER:
            begin
                state_next = lpg_pkg::ST_DRAW;
            end
            lpg_pkg::ST_DRAW:
            begin
                if (status.out_free && status.line_end)
                begin
                    state_next = lpg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            lpg_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            lpg_pkg::ST_SWAP:
            begin
                cmd.swap = 1'b1;
            end
            lpg_pkg::ST_ORDER:
            begin
                cmd.order = 1'b1;
            end
            lpg_pkg::ST_DRAW:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/core/lpg_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_datapath
// Endpoint registers, error accumulator and pixel output register.
// ----------------------------------------------------------------------------
module lpg_datapath
#(
    parameter int TILE_SIZE = lpg_pkg::TILE_SIZE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lpg_pkg::coord_t      start_x,
    input  lpg_pkg::coord_t      start_y,
    input  lpg_pkg::coord_t      end_x,
    input  lpg_pkg::coord_t      end_y,
    input  lpg_pkg::lpg_cmd_t    cmd,
    output lpg_pkg::lpg_status_t status,
    output lpg_pkg::coord_t      pixel_x,
    output lpg_pkg::coord_t      pixel_y,
    output logic                 last_pixel,
    output logic                 out_valid,
    input  logic                 out_ready
);

    localparam lpg_pkg::coord_t COORD_MAX = lpg_pkg::COORD_W'(TILE_SIZE - 1);

    function automatic lpg_pkg::coord_t clamp(input lpg_pkg::coord_t v);
        clamp = (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    function automatic lpg_pkg::coord_t abs_diff(input lpg_pkg::coord_t a,
                                                 input lpg_pkg::coord_t b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    lpg_pkg::coord_t ax_reg, ay_reg, bx_reg, by_reg;
    logic            steep_reg;
    lpg_pkg::coord_t major_reg, minor_reg, end_reg;
    lpg_pkg::coord_t d_major_reg;
    logic [lpg_pkg::COORD_W:0] step_err_reg;
    logic            up_reg;
    logic signed [lpg_pkg::ERR_W-1:0] err_reg;
    lpg_pkg::coord_t px_reg, py_reg;
    logic            last_reg;
    logic            valid_reg;

    lpg_pkg::coord_t dx, dy;
    logic            steep;
    logic            flip;
    lpg_pkg::coord_t o_major, o_minor, o_end, o_other;
    lpg_pkg::coord_t d_minor;
    logic signed [lpg_pkg::ERR_W-1:0] err_sum;
    logic signed [lpg_pkg::ERR_W-1:0] d_major_s;
    logic            err_over;

    assign dx    = abs_diff(ax_reg, bx_reg);
    assign dy    = abs_diff(ay_reg, by_reg);
    assign steep = dx < dy;

    assign flip    = ax_reg > bx_reg;
    assign o_major = flip ? bx_reg : ax_reg;
    assign o_minor = flip ? by_reg : ay_reg;
    assign o_end   = flip ? ax_reg : bx_reg;
    assign o_other = flip ? ay_reg : by_reg;
    assign d_minor = abs_diff(o_other, o_minor);

    assign d_major_s = $signed({{(lpg_pkg::ERR_W - lpg_pkg::COORD_W){1'b0}}, d_major_reg});
    assign err_sum   = err_reg
                     + $signed({{(lpg_pkg::ERR_W - lpg_pkg::COORD_W - 1){1'b0}}, step_err_reg});
    assign err_over  = err_sum > d_major_s;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg <= clamp(start_x);
            ay_reg <= clamp(start_y);
            bx_reg <= clamp(end_x);
            by_reg <= clamp(end_y);
        end
        else if (cmd.swap)
        begin
            steep_reg <= steep;
            if (steep)
            begin
                ax_reg <= ay_reg;
                ay_reg <= ax_reg;
                bx_reg <= by_reg;
                by_reg <= bx_reg;
            end
        end

        if (cmd.order)
        begin
            major_reg    <= o_major;
            minor_reg    <= o_minor;
            end_reg      <= o_end;
            d_major_reg  <= o_end - o_major;
            step_err_reg <= {d_minor, 1'b0};
            up_reg       <= o_other > o_minor;
            err_reg      <= '0;
        end
        else if (cmd.emit)
        begin
            major_reg <= major_reg + 1'b1;
            if (err_over)
            begin
                minor_reg <= up_reg ? (minor_reg + 1'b1) : (minor_reg - 1'b1);
                err_reg   <= err_sum - (d_major_s <<< 1);
            end
            else
            begin
                err_reg <= err_sum;
            end
        end

        if (cmd.emit)
        begin
            px_reg   <= steep_reg ? minor_reg : major_reg;
            py_reg   <= steep_reg ? major_reg : minor_reg;
            last_reg <= major_reg == end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign status.line_end = major_reg == end_reg;
    assign status.out_free = !valid_reg || out_ready;

    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign last_pixel = last_reg;
    assign out_valid  = valid_reg;

endmodule

/* rtl/core/line_pixel_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pixel_generator_unit
// Bresenham line rasteriser for a square tile of TILE_SIZE coordinates.
// ----------------------------------------------------------------------------
// Slave channel: one item holds two endpoints; coordinates at or above
// TILE_SIZE saturate to TILE_SIZE - 1. Master channel: one item per pixel,
// in order of increasing major coordinate, tlast on the final pixel.
// The endpoints are accepted, then the sequencer swaps the axes, orders
// the endpoints and takes the first step, which registers the first pixel.
// Throughput: a line of N pixels (1 to 64) is stepped out at one pixel per
// cycle while the master side does not stall; a new item is taken only
// once the final pixel of the line is in the output register, since the
// single error accumulator and minor-axis counter serve one line at a time.
// A stall on the master side holds the output register and freezes the
// stepping loop; once the final pixel sits in the output register the
// next item is accepted while that pixel waits.
// Reset clears the sequencer and the output valid flag; no line is in
// progress afterwards and s_tready is high.
// ----------------------------------------------------------------------------
module line_pixel_generator_unit
#(
    parameter int TILE_SIZE = lpg_pkg::TILE_SIZE_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lpg_pkg::S_DATA_W-1:0]  s_tdata,  // start_x, start_y, end_x, end_y
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lpg_pkg::M_DATA_W-1:0]  m_tdata,  // pixel_x, pixel_y, zero fill
    output logic                          m_tlast   // last_pixel
);

    localparam int CW = lpg_pkg::COORD_W;

    lpg_pkg::lpg_cmd_t    cmd;
    lpg_pkg::lpg_status_t status;
    lpg_pkg::coord_t      pixel_x;
    lpg_pkg::coord_t      pixel_y;

    lpg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lpg_datapath
    #(
        .TILE_SIZE (TILE_SIZE)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_x    (s_tdata[CW-1:0]),
        .start_y    (s_tdata[2*CW-1:CW]),
        .end_x      (s_tdata[3*CW-1:2*CW]),
        .end_y      (s_tdata[4*CW-1:3*CW]),
        .cmd        (cmd),
        .status     (status),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (m_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready)
    );

    assign m_tdata = {{(lpg_pkg::M_DATA_W - 2 * CW){1'b0}}, pixel_y, pixel_x};

endmodule

/* rtl/core/lpg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_checker
// Port-level checks on the line pixel generator, bound to the top level.
// ----------------------------------------------------------------------------
module lpg_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lpg_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                          m_tlast
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

    // drop ready for the setup cycles after an item is taken
    a_setup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input taken during line setup");

    // only a final pixel may wait while the block is ready
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && m_tvalid |-> m_tlast)
        else $error("ready while a line is unfinished");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[lpg_pkg::M_DATA_W-1:2*lpg_pkg::COORD_W] == '0)
        else $error("output padding not zero");

endmodule

bind line_pixel_generator_unit lpg_checker u_lpg_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
